// File: rtl/utf8v_pkg.sv
// Shared types and constants for the UTF-8 sequence validator.
package utf8v_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEAD  = 3'd1,
		ST_BAD_CONT  = 3'd2,
		ST_TRUNC     = 3'd3,
		ST_AFTER_ERR = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0] bytes_remaining;
		logic [2:0] current_length;
		logic [7:0] second_byte_min;
		logic       at_second_byte;
		logic       error_seen;
	} state_t;

	typedef struct packed {
		logic       char_end;
		logic [2:0] char_length;
		status_t    status;
		logic       string_valid;
	} res_t;

	localparam logic [7:0] CONT_MIN    = 8'h80;
	localparam logic [7:0] LEAD2_MIN   = 8'hC2;
	localparam logic [7:0] LEAD3_MIN   = 8'hE0;
	localparam logic [7:0] LEAD4_MIN   = 8'hF0;
	localparam logic [7:0] LEAD5_MIN   = 8'hF8;
	localparam logic [7:0] LEAD6_MIN   = 8'hFC;
	localparam logic [7:0] LEAD_BAD    = 8'hFE;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] SEC_MIN_3   = 8'hA0;
	localparam logic [7:0] SEC_MIN_4   = 8'h90;
	localparam logic [7:0] SEC_MIN_5   = 8'h88;
	localparam logic [7:0] SEC_MIN_6   = 8'h84;

	localparam state_t STATE_RESET = '{
		bytes_remaining: 3'd0,
		current_length:  3'd0,
		second_byte_min: CONT_MIN,
		at_second_byte:  1'b0,
		error_seen:      1'b0
	};

endpackage

// File: rtl/utf8_sequence_validator.sv
// Top level of the UTF-8 sequence validator: input register, decode, result register.
// Usage:
//   Slave channel s_* carries one byte of text per item in s_tdata, with s_tlast
//   on the final byte of each string. Master channel m_* returns exactly one
//   result item per input byte, in order, with m_tlast echoing s_tlast.
//   m_tdata bit 0 flags a completed character, bits 3:1 give its length (1..6,
//   0 if none), bits 6:4 the status (ok, bad lead, bad continuation/overlong,
//   truncated, after error) and bit 7 is set on a final byte of a valid string.
// Timing:
//   An accepted byte passes through the input register, then the result register. One byte
//   per cycle is sustained while m_tready stays high; the decode between the
//   two registers is a handful of byte compares and a 3-bit decrement.
// Reset:
//   arst_n clears both stage valids and the decode context; the first byte after
//   reset is treated as the start of a new string.
// Backpressure:
//   When m_tready is low the result holds; the input register accepts one more item
//   if it is empty, after which s_tready drops until the result is taken.
module utf8_sequence_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] char_end, [3:1] char_length, [6:4] status,
	                              // [7] string_valid
	output logic       m_tlast    // string_end
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              valid_s2;
	utf8v_pkg::res_t   res_s2;
	logic              last_s2;
	utf8v_pkg::state_t state_q;
	utf8v_pkg::state_t state_nxt;
	utf8v_pkg::res_t   res_nxt;
	logic              adv_s2;
	logic              adv_s1;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	utf8v_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// advance context only when the stage-1 item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= utf8v_pkg::STATE_RESET;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2  <= res_nxt;
			last_s2 <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.string_valid, res_s2.status, res_s2.char_length,
	                   res_s2.char_end};
	assign m_tlast  = last_s2;

`ifndef SYNTHESIS
	a_len_matches_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] != 3'd0)))
		else $error("char_length disagrees with char_end");

	a_valid_only_ok_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[7]) |-> (m_tlast && (m_tdata[6:4] == utf8v_pkg::ST_OK)))
		else $error("string_valid on a non-final or failing byte");

	a_no_open_char_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.bytes_remaining != 3'd0) |->
		(!state_q.error_seen && (state_q.bytes_remaining < 3'd6)))
		else $error("open character inconsistent with error state");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && last_s1) |=> (state_q == utf8v_pkg::STATE_RESET))
		else $error("context not cleared after final byte");
`endif

endmodule

// File: rtl/utf8v_step.sv
// Per-byte decode: lead and continuation checks, next state and result fields.
module utf8v_step (
	input  utf8v_pkg::state_t cur,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output utf8v_pkg::state_t nxt,
	output utf8v_pkg::res_t   res
);

	logic [2:0] lead_len;
	logic [7:0] lead_min;
	logic       cont_ok;
	logic [2:0] rem_dec;

	// classify a lead byte: length 0 means not a legal lead
	always_comb begin
		lead_min = utf8v_pkg::CONT_MIN;
		priority if (data_byte < utf8v_pkg::CONT_MIN) begin
			lead_len = 3'd1;
		end else if (data_byte < utf8v_pkg::LEAD2_MIN) begin
			lead_len = 3'd0;
		end else if (data_byte < utf8v_pkg::LEAD3_MIN) begin
			lead_len = 3'd2;
		end else if (data_byte < utf8v_pkg::LEAD4_MIN) begin
			lead_len = 3'd3;
			if (data_byte == utf8v_pkg::LEAD3_MIN) lead_min = utf8v_pkg::SEC_MIN_3;
		end else if (data_byte < utf8v_pkg::LEAD5_MIN) begin
			lead_len = 3'd4;
			if (data_byte == utf8v_pkg::LEAD4_MIN) lead_min = utf8v_pkg::SEC_MIN_4;
		end else if (data_byte < utf8v_pkg::LEAD6_MIN) begin
			lead_len = 3'd5;
			if (data_byte == utf8v_pkg::LEAD5_MIN) lead_min = utf8v_pkg::SEC_MIN_5;
		end else if (data_byte < utf8v_pkg::LEAD_BAD) begin
			lead_len = 3'd6;
			if (data_byte == utf8v_pkg::LEAD6_MIN) lead_min = utf8v_pkg::SEC_MIN_6;
		end else begin
			lead_len = 3'd0;
		end
	end

	// second byte must also clear the overlong bound
	assign cont_ok = ((data_byte & utf8v_pkg::CONT_MASK) == utf8v_pkg::CONT_MIN) &&
	                 !(cur.at_second_byte && (data_byte < cur.second_byte_min));
	assign rem_dec = cur.bytes_remaining - 3'd1;

	always_comb begin
		nxt              = cur;
		res.char_end     = 1'b0;
		res.char_length  = 3'd0;
		res.status       = utf8v_pkg::ST_OK;
		res.string_valid = 1'b0;
		if (cur.bytes_remaining == 3'd0) begin
			if (cur.error_seen) begin
				res.status = utf8v_pkg::ST_AFTER_ERR;
			end else if (lead_len == 3'd0) begin
				res.status     = utf8v_pkg::ST_BAD_LEAD;
				nxt.error_seen = 1'b1;
			end else if (lead_len == 3'd1) begin
				res.char_end    = 1'b1;
				res.char_length = 3'd1;
			end else if (last_byte) begin
				res.status     = utf8v_pkg::ST_TRUNC;
				nxt.error_seen = 1'b1;
			end else begin
				nxt.bytes_remaining = lead_len - 3'd1;
				nxt.current_length  = lead_len;
				nxt.second_byte_min = lead_min;
				nxt.at_second_byte  = 1'b1;
			end
		end else begin
			if (last_byte && (cur.bytes_remaining > 3'd1)) begin
				res.status          = utf8v_pkg::ST_TRUNC;
				nxt.error_seen      = 1'b1;
				nxt.bytes_remaining = 3'd0;
			end else if (!cont_ok) begin
				res.status          = utf8v_pkg::ST_BAD_CONT;
				nxt.error_seen      = 1'b1;
				nxt.bytes_remaining = 3'd0;
			end else begin
				nxt.bytes_remaining = rem_dec;
				if (rem_dec == 3'd0) begin
					res.char_end    = 1'b1;
					res.char_length = cur.current_length;
				end
			end
			nxt.at_second_byte = 1'b0;
			if (nxt.bytes_remaining == 3'd0) begin
				nxt.current_length  = 3'd0;
				nxt.second_byte_min = utf8v_pkg::CONT_MIN;
			end
		end
		res.string_valid = last_byte && !nxt.error_seen;
		// end of string: drop all context
		if (last_byte) nxt = utf8v_pkg::STATE_RESET;
	end

endmodule
